### rtl/core/c3dc_pkg.sv
// ----------------------------------------------------------------------------
// c3dc_pkg
// Shared constants and types of the 3x3 convolution filter.
// ----------------------------------------------------------------------------
package c3dc_pkg;

  localparam int MaxWidthDef  = 8192;
  localparam int CoeffBitsDef = 8;
  localparam int PixelBitsDef = 8;
  localparam int Planes       = 3;
  localparam int PosBits      = 13;
  localparam int SizeBits     = 14;
  localparam int DivBits      = 10;
  localparam int CoeffRegBits = 24;

  // Register indexes on the configuration port.
  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_DIV    = 3'd2,
    REG_CTOP   = 3'd3,
    REG_CMID   = 3'd4,
    REG_CBOT   = 3'd5
  } reg_idx_t;

  // Side information that travels with a request through the lane pipeline.
  typedef struct packed {
    logic               valid;
    logic [PosBits-1:0] row;
    logic [PosBits-1:0] col;
    logic               last;
  } c3dc_tag_t;

endpackage

### rtl/core/conv3x3_divide_clamp_top.sv
// ----------------------------------------------------------------------------
// conv3x3_divide_clamp_top
// 3x3 convolution over a three-plane raster stream with divide and clamp.
// ----------------------------------------------------------------------------
//  channel   dir  beat contents
//  s_axis    in   tdata: plane0, plane1, plane2
//  m_axis    out  tdata: plane0..2, row, col; tlast: frame_last
//  apb       in   six registers at 4*i
//
// One pixel is accepted every cycle while the output is free or taken.
// After its pixel is accepted, a result passes through the window
// register, the products, the adder tree, the sign split, one divider stage
// per quotient bit (20 stages) and the clamp before it is offered.
// The whole pipeline advances only when the output register is free or taken,
// so an output stall holds every stage and deasserts s_axis_tready.
// Reset clears counters, window and valid flags and sets the registers to defaults.
module conv3x3_divide_clamp_top #(
  parameter int MAX_WIDTH  = c3dc_pkg::MaxWidthDef,
  parameter int COEFF_BITS = c3dc_pkg::CoeffBitsDef,
  parameter int PIXEL_BITS = c3dc_pkg::PixelBitsDef
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // plane0, plane1, plane2
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,   // plane0, plane1, plane2, row, col, zeros
  output logic        m_axis_tlast,   // frame_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import c3dc_pkg::*;

  localparam int PixW    = Planes * PIXEL_BITS;
  localparam int ProdB   = PIXEL_BITS + COEFF_BITS + 1;
  // Products, adder tree, sign split, one stage per quotient bit, clamp.
  localparam int Latency = 4 + ProdB + 3;

  logic [SizeBits-1:0]     r_width, r_height;
  logic [DivBits-1:0]      r_div;
  logic [CoeffRegBits-1:0] r_top, r_mid, r_bot;
  reg_idx_t                idx;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_width  <= SizeBits'(640);
      r_height <= SizeBits'(480);
      r_div    <= DivBits'(1);
      r_top    <= '0;
      r_mid    <= CoeffRegBits'(256);
      r_bot    <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_WIDTH:  r_width  <= pwdata[SizeBits-1:0];
        REG_HEIGHT: r_height <= pwdata[SizeBits-1:0];
        REG_DIV:    r_div    <= pwdata[DivBits-1:0];
        REG_CTOP:   r_top    <= pwdata[CoeffRegBits-1:0];
        REG_CMID:   r_mid    <= pwdata[CoeffRegBits-1:0];
        REG_CBOT:   r_bot    <= pwdata[CoeffRegBits-1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_WIDTH:  prdata = 32'(r_width);
      REG_HEIGHT: prdata = 32'(r_height);
      REG_DIV:    prdata = 32'(r_div);
      REG_CTOP:   prdata = 32'(r_top);
      REG_CMID:   prdata = 32'(r_mid);
      REG_CBOT:   prdata = 32'(r_bot);
      default:    prdata = '0;
    endcase
  end

  logic adv;
  logic in_req;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_req        = s_axis_tvalid && adv;

  logic [8:0][PixW-1:0] win;
  c3dc_tag_t            tag0;

  c3dc_window #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_win (
    .clk(clk), .rst(rst), .in_req(in_req), .adv(adv),
    .pix({s_axis_tdata[23:16], s_axis_tdata[15:8], s_axis_tdata[7:0]}),
    .width(r_width), .height(r_height), .win(win), .tag(tag0)
  );

  logic [8:0][COEFF_BITS-1:0] coeff;
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      coeff[j]   = r_top[j*COEFF_BITS +: COEFF_BITS];
      coeff[3+j] = r_mid[j*COEFF_BITS +: COEFF_BITS];
      coeff[6+j] = r_bot[j*COEFF_BITS +: COEFF_BITS];
    end
  end

  logic [Planes-1:0][PIXEL_BITS-1:0] res;
  for (genvar p = 0; p < Planes; p++) begin : g_lane
    logic [8:0][PIXEL_BITS-1:0] pw;
    always_comb begin
      for (int k = 0; k < 9; k++) pw[k] = win[k][p*PIXEL_BITS +: PIXEL_BITS];
    end
    c3dc_lane #(.COEFF_BITS(COEFF_BITS), .PIXEL_BITS(PIXEL_BITS)) u_lane (
      .clk(clk), .win(pw), .coeff(coeff), .divisor(r_div), .en(adv),
      .result(res[p])
    );
  end

  // Tag delay line matching the lane latency.
  c3dc_tag_t tags [Latency];
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Latency; i++) tags[i] <= '0;
    end else if (adv) begin
      tags[0] <= tag0;
      for (int i = 1; i < Latency; i++) tags[i] <= tags[i-1];
    end
  end

  // Merging: the lanes' samples and the tag form one result, with no further register.
  assign m_axis_tvalid = tags[Latency-1].valid;
  assign m_axis_tdata  = {6'b000000, tags[Latency-1].col, tags[Latency-1].row,
                          res[2], res[1], res[0]};
  assign m_axis_tlast  = tags[Latency-1].last;

endmodule

### rtl/core/c3dc_lane.sv
// ----------------------------------------------------------------------------
// c3dc_lane
// One plane's datapath: nine products, an adder tree, a restoring divider
// that retires one quotient bit per stage, and the clamp to 0..255.
// ----------------------------------------------------------------------------
module c3dc_lane #(
  parameter int COEFF_BITS = c3dc_pkg::CoeffBitsDef,
  parameter int PIXEL_BITS = c3dc_pkg::PixelBitsDef
) (
  input  logic                                  clk,
  input  logic [8:0][PIXEL_BITS-1:0]            win,
  input  logic [8:0][COEFF_BITS-1:0]            coeff,
  input  logic [c3dc_pkg::DivBits-1:0]          divisor,
  input  logic                                  en,
  output logic [PIXEL_BITS-1:0]                 result
);
  import c3dc_pkg::*;

  localparam int ProdBits = PIXEL_BITS + COEFF_BITS + 1;
  localparam int SumBits  = ProdBits + 4;
  localparam int MagBits  = SumBits - 1;
  localparam int Stages   = MagBits;

  logic signed [ProdBits-1:0] prod [9];
  logic signed [SumBits-1:0]  sum_q;
  logic signed [SumBits-1:0]  sum_c;

  // Products are registered before the adder tree.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        prod[k] <= $signed({1'b0, win[k]}) * $signed(coeff[k]);
      end
    end
  end

  always_comb begin
    sum_c = '0;
    for (int k = 0; k < 9; k++) begin
      sum_c = sum_c + SumBits'(prod[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_q <= sum_c;
    end
  end

  // Restoring division of the magnitude, one quotient bit per stage.
  logic [MagBits-1:0] rem  [Stages+1];
  logic [MagBits-1:0] quo  [Stages+1];
  logic [MagBits-1:0] num  [Stages+1];
  logic [DivBits-1:0] dv   [Stages+1];
  logic               neg  [Stages+1];

  always_ff @(posedge clk) begin
    if (en) begin
      neg[0] <= sum_q[SumBits-1];
      num[0] <= sum_q[SumBits-1] ? MagBits'(-sum_q) : MagBits'(sum_q);
      rem[0] <= '0;
      quo[0] <= '0;
      dv[0]  <= (divisor == '0) ? DivBits'(1) : divisor;
    end
  end

  for (genvar s = 0; s < Stages; s++) begin : g_div
    logic [MagBits:0] trial;
    assign trial = {rem[s], num[s][MagBits-1-s]};
    always_ff @(posedge clk) begin
      if (en) begin
        neg[s+1] <= neg[s];
        num[s+1] <= num[s];
        dv[s+1]  <= dv[s];
        if (trial >= (MagBits+1)'(dv[s])) begin
          rem[s+1] <= MagBits'(trial - (MagBits+1)'(dv[s]));
          quo[s+1] <= {quo[s][MagBits-2:0], 1'b1};
        end else begin
          rem[s+1] <= MagBits'(trial);
          quo[s+1] <= {quo[s][MagBits-2:0], 1'b0};
        end
      end
    end
  end

  // A negative quotient clamps to zero; truncation toward zero of the
  // magnitude then matches the signed division.
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg[Stages] || quo[Stages] == '0) begin
        result <= '0;
      end else if (quo[Stages] > MagBits'(255)) begin
        result <= PIXEL_BITS'(255);
      end else begin
        result <= PIXEL_BITS'(quo[Stages]);
      end
    end
  end

endmodule

### rtl/core/c3dc_window.sv
// ----------------------------------------------------------------------------
// c3dc_window
// Raster position counters, the two line stores and the 3x3 window of
// packed pixels.
// ----------------------------------------------------------------------------
module c3dc_window #(
  parameter int MAX_WIDTH  = c3dc_pkg::MaxWidthDef,
  parameter int PIXEL_BITS = c3dc_pkg::PixelBitsDef
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      in_req,
  input  logic                                      adv,
  input  logic [c3dc_pkg::Planes*PIXEL_BITS-1:0]    pix,
  input  logic [c3dc_pkg::SizeBits-1:0]             width,
  input  logic [c3dc_pkg::SizeBits-1:0]             height,
  output logic [8:0][c3dc_pkg::Planes*PIXEL_BITS-1:0] win,
  output c3dc_pkg::c3dc_tag_t                       tag
);
  import c3dc_pkg::*;

  localparam int PixW  = Planes * PIXEL_BITS;
  localparam int AddrW = $clog2(MAX_WIDTH);

  logic [PixW-1:0]    store_a [MAX_WIDTH];
  logic [PixW-1:0]    store_b [MAX_WIDTH];
  logic [PosBits-1:0] col;
  logic [PosBits-1:0] row;
  logic [PosBits-1:0] col_next, row_next;
  logic [SizeBits-1:0] w_eff, h_eff;
  logic [SizeBits-1:0] col_p1, row_p1;
  logic [AddrW-1:0]   addr;
  logic               in_range;
  logic               take;

  assign w_eff    = (width  > SizeBits'(MAX_WIDTH)) ? SizeBits'(MAX_WIDTH) : width;
  assign h_eff    = (height > SizeBits'(MAX_WIDTH)) ? SizeBits'(MAX_WIDTH) : height;
  assign col_p1   = SizeBits'(col) + 1'b1;
  assign row_p1   = SizeBits'(row) + 1'b1;
  assign addr     = col[AddrW-1:0];
  assign in_range = SizeBits'(col) < SizeBits'(MAX_WIDTH);
  assign take     = in_req && !rst;

  always_comb begin
    col_next = col;
    row_next = row;
    if (rst) begin
      col_next = '0;
      row_next = '0;
    end else if (in_req) begin
      if (col_p1 >= w_eff) begin
        col_next = '0;
        row_next = (row_p1 >= h_eff) ? '0 : PosBits'(row_p1);
      end else begin
        col_next = PosBits'(col_p1);
      end
    end
  end

  // The stores are read into registers ahead, at the position of the next pixel.
  // When the counter stays on the same column, the entry being written is
  // forwarded instead of the stale contents.
  logic [PixW-1:0] above, above2;
  always_ff @(posedge clk) begin
    if (take && in_range) begin
      store_a[addr] <= pix;
      store_b[addr] <= above;
    end
    if (take && col_next == col) begin
      above  <= pix;
      above2 <= above;
    end else begin
      above  <= store_a[col_next[AddrW-1:0]];
      above2 <= store_b[col_next[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      win <= '0;
      tag <= '0;
    end else begin
      if (in_req) begin
        for (int k = 0; k < 3; k++) begin
          win[k*3]   <= win[k*3+1];
          win[k*3+1] <= win[k*3+2];
        end
        win[2] <= in_range ? above2 : '0;
        win[5] <= in_range ? above  : '0;
        win[8] <= pix;
        tag.valid <= (row >= PosBits'(2)) && (col >= PosBits'(2)) &&
                     (SizeBits'(row) < h_eff) && (SizeBits'(col) < w_eff);
        tag.row   <= row - 1'b1;
        tag.col   <= col - 1'b1;
        tag.last  <= (row_p1 == h_eff) && (col_p1 == w_eff);
        col <= col_next;
        row <= row_next;
      end else if (adv) begin
        tag.valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/core/c3dc_checker.sv
// ----------------------------------------------------------------------------
// c3dc_checker
// Port-level checks of the convolution filter, bound to the top level.
// ----------------------------------------------------------------------------
module c3dc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic        pready
);
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result changed while stalled");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output space");

  a_interior: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[36:24] != 13'd0 && m_axis_tdata[49:37] != 13'd0)
    else $error("result outside interior");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");
endmodule

bind conv3x3_divide_clamp_top c3dc_checker u_chk (.*);
